// ===== hdl/irtd_pkg.sv =====
package irtd_pkg;

  // Configuration register and payload widths
  localparam int BASE_W  = 6;
  localparam int VALUE_W = 32;
  localparam int CHAR_W  = 7;
  localparam int REM_W   = 6;

  // Default operand width used by the core
  localparam int NUMBER_BITS_DEFAULT = 32;

  localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
  localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;

  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_LETTER = 7'd65;
  localparam logic [REM_W-1:0]  DEC_LIMIT   = 6'd10;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic pop_en;
  } irtd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic step_last;
    logic quo_zero;
    logic pop_last;
  } irtd_status_t;

  // Clamp the programmed radix into 2..36
  function automatic logic [BASE_W-1:0] eff_base(input logic [BASE_W-1:0] b);
    logic [BASE_W-1:0] r;
    if (b < BASE_MIN) begin
      r = BASE_MIN;
    end else if (b > BASE_MAX) begin
      r = BASE_MAX;
    end else begin
      r = b;
    end
    return r;
  endfunction

  // Map a digit value 0..35 to its ASCII character
  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [REM_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_LIMIT) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_LETTER + CHAR_W'(d - DEC_LIMIT);
    end
    return c;
  endfunction

endpackage

// ===== hdl/irtd_controller.sv =====
module irtd_controller
  import irtd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  irtd_status_t status,
  output irtd_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  state_t state;

  // Accept a new value only when the previous digits have all left the stack
  assign in_ready   = (state == ST_IDLE);
  assign cmd.load   = in_valid && (state == ST_IDLE);
  assign cmd.step   = (state == ST_DIVIDE);
  assign cmd.pop_en = (state == ST_EMIT);

  // Sequence: load, divide digit by digit, then drain the digit stack
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          if (status.step_last && status.quo_zero) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (status.pop_last) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/irtd_datapath.sv =====
module irtd_datapath
  import irtd_pkg::*;
#(
  parameter int NUMBER_BITS = NUMBER_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [BASE_W-1:0]  cfg_wr_data,
  input  logic [VALUE_W-1:0] value,
  input  irtd_cmd_t          cmd,
  output irtd_status_t       status,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CHAR_W-1:0]  digit_char,
  output logic               last_digit
);

  localparam int VAL_W = (NUMBER_BITS < VALUE_W) ? NUMBER_BITS : VALUE_W;
  localparam int CNT_W = $clog2(VAL_W);
  localparam int IDX_W = $clog2(VAL_W);
  localparam int SP_W  = $clog2(VAL_W + 1);

  logic [BASE_W-1:0] base_reg;
  logic [BASE_W-1:0] base_q;
  logic [VAL_W-1:0]  quo;
  logic [REM_W-1:0]  rem;
  logic [CNT_W-1:0]  cnt;
  logic [SP_W-1:0]   sp;
  logic [REM_W-1:0]  stack [VAL_W];

  logic [REM_W:0]    trial;
  logic [REM_W:0]    diff;
  logic              ge;
  logic [REM_W-1:0]  rem_next;
  logic [VAL_W-1:0]  quo_next;
  logic [SP_W-1:0]   sp_m1;
  logic              pop_fire;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      base_reg <= BASE_RESET;
    end else if (cfg_wr_en) begin
      base_reg <= cfg_wr_data;
    end
  end

  // One restoring division step: shift in a dividend bit, subtract if it fits
  assign trial    = {rem, quo[VAL_W-1]};
  assign diff     = trial - {1'b0, base_q};
  assign ge       = (trial >= {1'b0, base_q});
  assign rem_next = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
  assign quo_next = {quo[VAL_W-2:0], ge};

  assign sp_m1    = sp - SP_W'(1);
  assign pop_fire = cmd.pop_en && (sp != '0) && (!out_valid || out_ready);

  assign status.step_last = (cnt == CNT_W'(VAL_W - 1));
  assign status.quo_zero  = (quo_next == '0);
  assign status.pop_last  = pop_fire && (sp == SP_W'(1));

  // Divider registers and stack pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      sp  <= '0;
    end else if (cmd.load) begin
      cnt <= '0;
      sp  <= '0;
    end else if (cmd.step) begin
      if (status.step_last) begin
        cnt <= '0;
        sp  <= sp + SP_W'(1);
      end else begin
        cnt <= cnt + CNT_W'(1);
      end
    end else if (pop_fire) begin
      sp <= sp_m1;
    end
  end

  // Dividend, partial remainder and radix of the current value
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo    <= value[VAL_W-1:0];
      rem    <= '0;
      base_q <= eff_base(base_reg);
    end else if (cmd.step) begin
      quo <= quo_next;
      rem <= status.step_last ? '0 : rem_next;
    end
  end

  // Push each finished remainder; least significant digit goes in first
  always_ff @(posedge clk) begin
    if (cmd.step && status.step_last) begin
      stack[sp[IDX_W-1:0]] <= rem_next;
    end
  end

  // Output register: pop the top digit whenever the slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_fire) begin
      digit_char <= digit_ascii(stack[sp_m1[IDX_W-1:0]]);
      last_digit <= (sp == SP_W'(1));
    end
  end

endmodule

// ===== hdl/integer_to_radix_digits_core.sv =====
// Channel  Signals                       Width    Beat
// in       in_valid/in_ready, value      32       one integer to convert
// out      out_valid/out_ready,          7 + 1    one ASCII digit, MSD first,
//          digit_char, last_digit                 last_digit on the final one
// cfg      cfg_wr_en, cfg_wr_data        6        radix, reset 10, 2..36
//
// One bit-serial restoring divider produces one quotient bit per cycle; each
// digit takes one pass over all W dividend bits, W = min(NUMBER_BITS, 32),
// and the digits then drain from the digit stack while out_ready allows.
// in_ready is high only while no value is being converted; the last digit may
// still wait in the output register while the next value is accepted.
// rst is synchronous and active high; it clears the radix to 10.
module integer_to_radix_digits_core
  import irtd_pkg::*;
#(
  parameter int NUMBER_BITS = NUMBER_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [BASE_W-1:0]  cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VALUE_W-1:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CHAR_W-1:0]  digit_char,
  output logic               last_digit
);

  irtd_cmd_t    cmd;
  irtd_status_t status;

  irtd_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  irtd_datapath #(
    .NUMBER_BITS (NUMBER_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .value       (value),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digit_char  (digit_char),
    .last_digit  (last_digit)
  );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import irtd_pkg::*;

  localparam int RANDOM_ITEMS = 150;
  localparam int STALL_LIMIT  = 20000;
  localparam int LONG_HOLD    = 2000;
  localparam int DRAIN_CYCLES = 1100;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } digit_t;

  typedef struct {
    logic [BASE_W-1:0]  base;
    logic [VALUE_W-1:0] val;
    string              digits;
  } directed_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en;
  logic [BASE_W-1:0]  cfg_wr_data;
  logic               in_valid;
  logic               in_ready;
  logic [VALUE_W-1:0] value;
  logic               out_valid;
  logic               out_ready;
  logic [CHAR_W-1:0]  digit_char;
  logic               last_digit;

  // Radix as last written, and the digits still owed by the block
  logic [BASE_W-1:0] radix_setting;
  digit_t            pending_digits[$];
  int                errors = 0;
  bit                quiet = 1'b0;
  bit                hold_now = 1'b0;

  // Directed rows: an empty digit string means the predictor fills it in
  directed_row_t directed_rows[19] = '{
    '{6'd10, 32'd0,          "0"},
    '{6'd10, 32'hFFFFFFFF,   "4294967295"},
    '{6'd10, 32'd9,          "9"},
    '{6'd10, 32'd10,         "10"},
    '{6'd10, 32'd12345,      ""},
    '{6'd0,  32'd5,          "101"},
    '{6'd0,  32'd0,          "0"},
    '{6'd1,  32'hFFFFFFFF,   "11111111111111111111111111111111"},
    '{6'd2,  32'h80000000,   "10000000000000000000000000000000"},
    '{6'd16, 32'hDEADBEEF,   "DEADBEEF"},
    '{6'd16, 32'hFFFFFFFF,   "FFFFFFFF"},
    '{6'd36, 32'd35,         "Z"},
    '{6'd36, 32'd36,         "10"},
    '{6'd36, 32'hFFFFFFFF,   ""},
    '{6'd37, 32'd35,         "Z"},
    '{6'd63, 32'd0,          "0"},
    '{6'd63, 32'hFFFFFFFF,   ""},
    '{6'd8,  32'h12345678,   ""},
    '{6'd3,  32'hFFFFFFFF,   ""}
  };

  integer_to_radix_digits_core dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digit_char  (digit_char),
    .last_digit  (last_digit)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Radix actually used: out-of-range settings saturate to 2 or 36
  function automatic logic [BASE_W-1:0] radix_in_use();
    if (radix_setting < 6'd2) return 6'd2;
    if (radix_setting > 6'd36) return 6'd36;
    return radix_setting;
  endfunction

  // Divide down by the radix and queue the digits most significant first
  function automatic void predict_digits(input logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] rest;
    logic [VALUE_W-1:0] b;
    logic [5:0]         d;
    digit_t             stack[$];
    digit_t             dg;
    b = VALUE_W'(radix_in_use());
    rest = v;
    do begin
      d = 6'(rest % b);
      dg.ch = (d < 6'd10) ? CHAR_ZERO + CHAR_W'(d) : CHAR_LETTER + CHAR_W'(d - 6'd10);
      dg.last = (stack.size() == 0);
      stack.push_front(dg);
      rest = rest / b;
    end while (rest != 0);
    foreach (stack[i]) pending_digits.push_back(stack[i]);
  endfunction

  // Mostly short gaps, a few long ones, none in a quiet phase
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Mix of zero, all-ones, full-range, shortened, tiny and power-of-radix values
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [63:0] p;
    int          r;
    int          k;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 15) return '1;
    if (r < 35) return VALUE_W'($urandom_range(0, 2 * radix_in_use()));
    if (r < 50) begin
      p = 64'd1;
      k = $urandom_range(1, 31);
      while (k > 0 && p * radix_in_use() <= 64'hFFFFFFFF) begin
        p = p * radix_in_use();
        k--;
      end
      return VALUE_W'(p - $urandom_range(0, 1));
    end
    if (r < 70) return $urandom() >> $urandom_range(1, 31);
    return $urandom();
  endfunction

  // Drain the block, then write the radix while it is idle
  task automatic write_radix(input logic [BASE_W-1:0] b);
    in_valid <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= b;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    radix_setting = b;
  endtask

  // Offer one value after a random gap; queue its digits once taken
  task automatic send_value(input logic [VALUE_W-1:0] v, input string digits);
    int     gap;
    digit_t dg;
    byte    c;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    do @(posedge clk); while (!in_ready);
    if (digits.len() == 0) begin
      predict_digits(v);
    end else begin
      for (int i = 0; i < digits.len(); i++) begin
        c = digits[i];
        dg.ch = c[CHAR_W-1:0];
        dg.last = (i == digits.len() - 1);
        pending_digits.push_back(dg);
      end
    end
  endtask

  // Stimulus: directed table, then random phases with a radix each
  initial begin : stimulus
    int sent;
    int phase;
    int n;
    logic [BASE_W-1:0] extremes[6];
    extremes = '{6'd2, 6'd36, 6'd0, 6'd63, 6'd1, 6'd37};
    in_valid    = 1'b0;
    value       = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    radix_setting = BASE_RESET;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].base != radix_setting) write_radix(directed_rows[i].base);
      send_value(directed_rows[i].val, directed_rows[i].digits);
    end

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      write_radix((phase < 6) ? extremes[phase] : BASE_W'($urandom_range(0, 63)));
      quiet = ($urandom_range(0, 3) == 0);
      n = $urandom_range(10, 30);
      for (int k = 0; k < n && sent < RANDOM_ITEMS; k++) begin
        send_value(pick_value(), "");
        sent++;
        // stall the sink mid-phase so the block backs up into its input
        if (phase == 0 && k == 5) hold_now = 1'b1;
      end
      phase++;
    end

    in_valid <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Sink: random ready gaps plus one long hold-off
  initial begin : sink
    int stall;
    bit held;
    held = 1'b0;
    out_ready = 1'b0;
    wait (!rst);
    forever begin
      if (hold_now && !held) begin
        held = 1'b1;
        stall = LONG_HOLD;
      end else begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Compare each digit beat with the oldest one owed
  always @(posedge clk) begin : check_digits
    digit_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_digits.size() == 0) begin
        $display("%0t: unexpected digit beat, char %0d last %0b", $time, digit_char,
                 last_digit);
        errors++;
      end else begin
        want = pending_digits.pop_front();
        if (digit_char !== want.ch) begin
          $display("%0t: digit_char expected %0d got %0d", $time, want.ch, digit_char);
          errors++;
        end
        if (last_digit !== want.last) begin
          $display("%0t: last_digit expected %0b got %0b", $time, want.last, last_digit);
          errors++;
        end
      end
    end
  end

  // Watchdog: give up when no beat moves for too long
  initial begin : watchdog
    int stale;
    stale = 0;
    while (stale < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stale = 0;
      else stale++;
    end
    $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
    $display("testbench: errors");
    $finish;
  end

endmodule
